[design/sawarq_pkg.sv]
package sawarq_pkg;

    // sizes
    localparam int NumLinks   = 8;
    localparam int LAddrW     = (NumLinks > 1) ? $clog2(NumLinks) : 1;
    localparam int LSlots     = 1 << LAddrW;
    localparam int QueueDepth = 16;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);
    // result queue depth, a power of two
    localparam int OutDepth   = 4;
    localparam int OqPtrW     = $clog2(OutDepth);
    localparam int OqCntW     = $clog2(OutDepth + 1);

    localparam logic [15:0] ResetTicks = 16'd1000;

    // input item kinds
    typedef enum logic [1:0] {
        MODE_SEND = 2'd0,
        MODE_RECV = 2'd1,
        MODE_TICK = 2'd2
    } t_mode;

    // result actions
    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_SEND     = 3'd1,
        ACT_ACK      = 3'd2,
        ACT_DELIVER  = 3'd3,
        ACT_BAD_CRC  = 3'd4,
        ACT_WRONG    = 3'd5,
        ACT_OVERFLOW = 3'd6,
        ACT_EMPTY    = 3'd7
    } t_action;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] link;
        logic       frame_is_data;
        logic       seq_bit;
        logic       crc_ok;
        logic [7:0] payload_handle;
        logic       from_application;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] out_link;
        logic       out_seq;
        logic [7:0] out_handle;
        logic       app_enabled;
        logic       last;
    } t_out_item;

    // one queued frame
    typedef struct packed {
        logic [2:0] link;
        logic       seq;
        logic [7:0] handle;
    } t_entry;

    // per-link sequence state
    typedef struct packed {
        logic send_b;
        logic exp_ack;
        logic exp_data;
    } t_lbits;

    // results written into the result queue in the same cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

    // frame queue index advance with wrap
    function automatic logic [QPtrW-1:0] q_next(input logic [QPtrW-1:0] idx);
        logic [QPtrW-1:0] res;
        if (int'(idx) + 1 >= QueueDepth) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

endpackage

[design/sawarq_ram.sv]
module sawarq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // one write port, one registered read port (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/sawarq_outq.sv]
module sawarq_outq
    import sawarq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    output logic [OqCntW-1:0] o_count,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_item
);

    t_out_item         r_q [OutDepth];
    logic [OqPtrW-1:0] r_wr;
    logic [OqPtrW-1:0] r_rd;
    logic [OqCntW-1:0] r_cnt;
    logic              pop;

    assign pop = (r_cnt != '0) && !i_stall;

    // result storage, up to two writes a cycle
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_wr] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[OqPtrW'(r_wr + 1'b1)] <= i_push.item1;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= OqPtrW'(r_wr + OqPtrW'(i_push.cnt));
            r_rd  <= OqPtrW'(r_rd + OqPtrW'(pop));
            r_cnt <= OqCntW'(r_cnt + OqCntW'(i_push.cnt) - OqCntW'(pop));
        end
    end

    assign o_count = r_cnt;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd];

endmodule

[design/stop_and_wait_arq_link_core.sv]
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------------
// in        | input     | i_in_valid / o_in_stall   | i_in (t_in_item)
// out       | output    | o_out_valid / i_out_stall | o_out (t_out_item)
// cfg       | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (retransmit ticks)
//
// an item is taken into a stage register while the per-link bit memory and the
// frame memory are read, then it is resolved and written back in the next cycle.
// one item per cycle is accepted while the result queue has room; items with two
// results are slowed by the single result port.
// reset is synchronous active low; the per-link bits read as zero until written.
// o_in_stall rises when the result queue could not hold another item's results.
module stop_and_wait_arq_link_core
    import sawarq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    // config
    logic [15:0] r_ticks;

    // resolve stage
    logic     r_s1_vld;
    t_in_item r_s1;

    // queue control and timer
    logic [QPtrW-1:0] r_head, n_head;
    logic [QPtrW-1:0] r_tail, n_tail;
    logic [QCntW-1:0] r_cnt, n_cnt;
    logic [15:0]      r_rem, n_rem;
    logic             r_run, n_run;
    logic             r_app, n_app;
    t_entry           r_head_ent, n_head_ent;

    // link bit memory access
    logic [LSlots-1:0] r_lvld;
    logic              r_lb_vld;
    logic              r_lb_fwd;
    t_lbits            r_lb_fwd_data;
    t_lbits            lb_rdata, lb_cur, lb_new;
    logic              lb_we;
    logic [LAddrW-1:0] lb_waddr, lb_raddr;

    // frame memory access
    logic             r_fe_fwd;
    t_entry           r_fe_fwd_data;
    t_entry           fe_rdata, fe_cur, fe_wdata;
    logic             fe_we;
    logic [QPtrW-1:0] fe_raddr;

    // results
    t_out_item         res0, res1;
    logic [1:0]        push_cnt;
    t_push             push;
    logic [OqCntW-1:0] oq_cnt;
    logic              accept;
    logic              link_ok;

    assign o_cfg_ready = 1'b1;

    // retransmit interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= ResetTicks;
        end else if (i_cfg_valid) begin
            r_ticks <= i_cfg_data;
        end
    end

    // input acceptance, room for two results beyond what is already due
    assign o_in_stall = (int'(oq_cnt) + int'(push_cnt)) > (OutDepth - 2);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_in;
        end
    end

    // memories
    assign lb_raddr = i_in.link[LAddrW-1:0];
    assign lb_waddr = r_s1.link[LAddrW-1:0];

    sawarq_ram #(
        .Width ($bits(t_lbits)),
        .Depth (LSlots)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (lb_new),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    assign fe_raddr = q_next(n_head);

    sawarq_ram #(
        .Width ($bits(t_entry)),
        .Depth (QueueDepth)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fe_we),
        .i_waddr (r_tail),
        .i_wdata (fe_wdata),
        .i_raddr (fe_raddr),
        .o_rdata (fe_rdata)
    );

    // forwarding of same-cycle writes and link valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld   <= '0;
            r_lb_vld <= 1'b0;
            r_lb_fwd <= 1'b0;
            r_fe_fwd <= 1'b0;
        end else begin
            if (lb_we) begin
                r_lvld[lb_waddr] <= 1'b1;
            end
            r_lb_vld <= r_lvld[lb_raddr];
            r_lb_fwd <= lb_we && (lb_waddr == lb_raddr);
            r_fe_fwd <= fe_we && (r_tail == fe_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lb_fwd_data <= lb_new;
        r_fe_fwd_data <= fe_wdata;
    end

    assign lb_cur  = r_lb_fwd ? r_lb_fwd_data : (r_lb_vld ? lb_rdata : '0);
    assign fe_cur  = r_fe_fwd ? r_fe_fwd_data : fe_rdata;
    assign link_ok = int'(r_s1.link) < NumLinks;

    // resolve one item: protocol update and its results
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        n_rem      = r_rem;
        n_run      = r_run;
        n_app      = r_app;
        n_head_ent = r_head_ent;
        lb_new     = lb_cur;
        lb_we      = 1'b0;
        fe_we      = 1'b0;
        fe_wdata   = '{link: r_s1.link, seq: lb_cur.send_b, handle: r_s1.payload_handle};
        res0       = '0;
        res0.last  = 1'b1;
        res1       = '0;
        res1.last  = 1'b1;
        push_cnt   = 2'd0;
        if (r_s1_vld) begin
            push_cnt = 2'd1;
            case (r_s1.mode)
                MODE_TICK: begin
                    if (r_run) begin
                        if (r_rem > 16'd1) begin
                            n_rem = r_rem - 16'd1;
                        end else if (r_cnt == '0) begin
                            n_rem       = '0;
                            n_run       = 1'b0;
                            res0.action = ACT_EMPTY;
                        end else begin
                            // expiry: resend head frame
                            n_rem           = r_ticks;
                            n_run           = 1'b1;
                            res0.action     = ACT_SEND;
                            res0.out_link   = r_head_ent.link;
                            res0.out_seq    = r_head_ent.seq;
                            res0.out_handle = r_head_ent.handle;
                        end
                    end
                end
                MODE_SEND: begin
                    if (link_ok) begin
                        lb_we = 1'b1;
                        if (r_cnt >= QCntW'(QueueDepth)) begin
                            res0.action   = ACT_OVERFLOW;
                            res0.out_link = r_s1.link;
                        end else begin
                            fe_we         = 1'b1;
                            n_tail        = q_next(r_tail);
                            n_cnt         = r_cnt + 1'b1;
                            lb_new.send_b = ~lb_cur.send_b;
                            if (r_s1.from_application) begin
                                n_app = 1'b0;
                            end
                            // empty queue: goes out at once
                            if (r_cnt == '0) begin
                                n_head_ent      = fe_wdata;
                                n_rem           = r_ticks;
                                n_run           = 1'b1;
                                res0.action     = ACT_SEND;
                                res0.out_link   = fe_wdata.link;
                                res0.out_seq    = fe_wdata.seq;
                                res0.out_handle = fe_wdata.handle;
                            end
                        end
                    end
                end
                MODE_RECV: begin
                    if (link_ok) begin
                        lb_we = 1'b1;
                        if (!r_s1.crc_ok) begin
                            res0.action   = ACT_BAD_CRC;
                            res0.out_link = r_s1.link;
                            res0.out_seq  = r_s1.seq_bit;
                        end else if (r_s1.frame_is_data) begin
                            // data is always acked, delivered when expected
                            res0.action   = ACT_ACK;
                            res0.out_link = r_s1.link;
                            res0.out_seq  = r_s1.seq_bit;
                            if (r_s1.seq_bit == lb_cur.exp_data) begin
                                lb_new.exp_data = ~lb_cur.exp_data;
                                res0.last       = 1'b0;
                                res1.action     = ACT_DELIVER;
                                res1.out_link   = r_s1.link;
                                res1.out_seq    = r_s1.seq_bit;
                                res1.out_handle = r_s1.payload_handle;
                                push_cnt        = 2'd2;
                            end
                        end else if (r_s1.seq_bit != lb_cur.exp_ack) begin
                            res0.action   = ACT_WRONG;
                            res0.out_link = r_s1.link;
                            res0.out_seq  = r_s1.seq_bit;
                        end else begin
                            // matching ack
                            lb_new.exp_ack = ~lb_cur.exp_ack;
                            n_run          = 1'b0;
                            n_rem          = '0;
                            n_app          = 1'b1;
                            res0.out_link  = r_s1.link;
                            if (r_cnt == '0) begin
                                res0.action = ACT_EMPTY;
                            end else begin
                                n_head = q_next(r_head);
                                n_cnt  = r_cnt - 1'b1;
                                if (r_cnt != QCntW'(1)) begin
                                    n_head_ent      = fe_cur;
                                    n_rem           = r_ticks;
                                    n_run           = 1'b1;
                                    res0.action     = ACT_SEND;
                                    res0.out_link   = fe_cur.link;
                                    res0.out_seq    = fe_cur.seq;
                                    res0.out_handle = fe_cur.handle;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        res0.app_enabled = n_app;
        res1.app_enabled = n_app;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_run  <= 1'b0;
            r_app  <= 1'b1;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
            r_rem  <= n_rem;
            r_run  <= n_run;
            r_app  <= n_app;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_ent <= n_head_ent;
    end

    // result queue
    assign push = '{cnt: push_cnt, item0: res0, item1: res1};

    sawarq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (oq_cnt),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out)
    );

endmodule
